FILE: rtl/alr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

    localparam int unsigned LOOP_DEPTH_DEF  = 262144;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_REC   = 2'd1,
        MODE_READY = 2'd2,
        MODE_LOOP  = 2'd3
    } mode_t;

    localparam logic [2:0] REQ_REC_TOGGLE  = 3'd0;
    localparam logic [2:0] REQ_LOOP_TOGGLE = 3'd1;
    localparam logic [2:0] REQ_PASS_SAMPLE = 3'd2;
    localparam logic [2:0] REQ_REC_SAMPLE  = 3'd3;
    localparam logic [2:0] REQ_PLAY_TICK   = 3'd4;

    localparam logic [6:0] TOGGLE_ON = 7'd127;

endpackage

`default_nettype wire

FILE: rtl/alr_store.sv
`timescale 1ns / 1ps
`default_nettype none

module alr_store #(
    parameter int unsigned DEPTH  = alr_pkg::LOOP_DEPTH_DEF,
    parameter int unsigned DATA_W = alr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read so a stalled result keeps its sample
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/audio_loop_recorder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Fields
// input     in_valid / in_stall     req_type, ctrl_value, sample_in
// output    out_valid / out_stall   sample_out, sample_valid, mode_now, store_full, refused
//
// One beat per cycle sustained while the output is not stalled; a result passes through
// the store read stage, then the output register, since the loop store read is registered.
// Reset clears mode, loop length and play position; the store itself is not cleared
// and needs no clearing pass.
// The read stage keeps taking beats while the output register waits; input stalls only
// when both stages hold results and the output is stalled.

module audio_loop_recorder #(
    parameter int unsigned LOOP_DEPTH  = alr_pkg::LOOP_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    req_type,
    input  wire logic [6:0]                    ctrl_value,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               sample_valid,
    output logic [1:0]                         mode_now,
    output logic                               store_full,
    output logic                               refused
);

    localparam int unsigned ADDR_W = $clog2(LOOP_DEPTH);
    localparam int unsigned LEN_W  = $clog2(LOOP_DEPTH + 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(LOOP_DEPTH);

    alr_pkg::mode_t    mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_from_store_reg;
    logic                   s1_svalid_reg;
    logic [1:0]             s1_mode_reg;
    logic                   s1_full_reg;
    logic                   s1_refused_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic                   sample_valid_reg;
    logic [1:0]             mode_now_reg;
    logic                   store_full_reg;
    logic                   refused_reg;

    logic                   accept;
    logic                   s1_move;
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      play_idx;
    logic [LEN_W-1:0]       play_inc;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] res_sample;
    logic                   res_from_store;
    logic                   res_svalid;
    logic                   res_full;
    logic                   res_refused;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    assign play_idx = (LEN_W'(pos_reg) >= len_reg) ? '0 : pos_reg;
    assign play_inc = LEN_W'(play_idx) + LEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= alr_pkg::MODE_PASS;
            len_reg  <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            pos_reg  <= pos_next;
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        res_sample     = '0;
        res_from_store = 1'b0;
        res_svalid     = 1'b0;
        res_full       = 1'b0;
        res_refused    = 1'b0;
        if (accept)
        begin
            case (req_type)
                alr_pkg::REQ_REC_TOGGLE:
                begin
                    if (ctrl_value == alr_pkg::TOGGLE_ON)
                    begin
                        case (mode_reg)
                            alr_pkg::MODE_PASS, alr_pkg::MODE_READY:
                            begin
                                len_next  = '0;
                                pos_next  = '0;
                                mode_next = alr_pkg::MODE_REC;
                            end
                            alr_pkg::MODE_REC:
                            begin
                                mode_next = alr_pkg::MODE_READY;
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
                alr_pkg::REQ_LOOP_TOGGLE:
                begin
                    if (ctrl_value == alr_pkg::TOGGLE_ON)
                    begin
                        case (mode_reg)
                            alr_pkg::MODE_REC, alr_pkg::MODE_READY:
                            begin
                                pos_next  = '0;
                                mode_next = alr_pkg::MODE_LOOP;
                            end
                            alr_pkg::MODE_LOOP:
                            begin
                                mode_next = alr_pkg::MODE_READY;
                            end
                            default:
                            begin
                                mode_next = mode_reg;
                            end
                        endcase
                    end
                end
                alr_pkg::REQ_PASS_SAMPLE:
                begin
                    if (mode_reg == alr_pkg::MODE_LOOP)
                    begin
                        res_refused = 1'b1;
                    end
                    else
                    begin
                        res_sample = sample_in;
                        res_svalid = 1'b1;
                    end
                end
                alr_pkg::REQ_REC_SAMPLE:
                begin
                    if (mode_reg == alr_pkg::MODE_REC)
                    begin
                        if (len_reg < DEPTH_LEN)
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            res_full = 1'b1;
                        end
                    end
                end
                alr_pkg::REQ_PLAY_TICK:
                begin
                    if (mode_reg == alr_pkg::MODE_LOOP && len_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        res_from_store = 1'b1;
                        res_svalid     = 1'b1;
                        // wrap at the loop end
                        pos_next = (play_inc >= len_reg) ? '0 : play_inc[ADDR_W-1:0];
                    end
                end
                default:
                begin
                    res_svalid = 1'b0;
                end
            endcase
        end
    end

    alr_store #(
        .DEPTH  (LOOP_DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (sample_in),
        .rd_en   (rd_en),
        .rd_addr (play_idx),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg     <= res_sample;
            s1_from_store_reg <= res_from_store;
            s1_svalid_reg     <= res_svalid;
            s1_mode_reg       <= mode_next;
            s1_full_reg       <= res_full;
            s1_refused_reg    <= res_refused;
        end
        if (s1_move)
        begin
            sample_out_reg   <= s1_from_store_reg ? rd_data : s1_sample_reg;
            sample_valid_reg <= s1_svalid_reg;
            mode_now_reg     <= s1_mode_reg;
            store_full_reg   <= s1_full_reg;
            refused_reg      <= s1_refused_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_out   = sample_out_reg;
    assign sample_valid = sample_valid_reg;
    assign mode_now     = mode_now_reg;
    assign store_full   = store_full_reg;
    assign refused      = refused_reg;

endmodule

`default_nettype wire

FILE: rtl/alr_check.sv
`timescale 1ns / 1ps
`default_nettype none

module alr_check #(
    parameter int unsigned SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [SAMPLE_BITS-1:0] sample_out,
    input wire logic                   sample_valid,
    input wire logic [1:0]             mode_now,
    input wire logic                   store_full,
    input wire logic                   refused
);

    // a sample beat carries neither refused nor store_full
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_valid) |-> (!refused && !store_full))
        else $error("sample beat also flags refused or store_full");

    a_refused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && refused) |-> (mode_now == alr_pkg::MODE_LOOP))
        else $error("refused outside looping");

    a_full_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && store_full) |-> (mode_now == alr_pkg::MODE_REC))
        else $error("store_full outside recording");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sample_valid) |-> (sample_out == '0))
        else $error("sample_out nonzero without sample_valid");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(mode_now)))
        else $error("stalled output beat changed");

endmodule

bind audio_loop_recorder alr_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_alr_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .sample_valid (sample_valid),
    .mode_now     (mode_now),
    .store_full   (store_full),
    .refused      (refused)
);

`default_nettype wire
